// ===== hdl/lzss_stream_decoder_top_macros.svh =====
// ---------------------------------------------------------------------------
// lzss stream decoder assertion macros
// immediate-consequence and next-cycle property wrappers on clk / arst_n
// ---------------------------------------------------------------------------
`ifndef LZSS_STREAM_DECODER_TOP_MACROS_SVH
`define LZSS_STREAM_DECODER_TOP_MACROS_SVH

// consequence holds in the same cycle
`define LZSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the following cycle
`define LZSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lzsd_pkg.sv =====
// ---------------------------------------------------------------------------
// lzsd_pkg
// types and constants shared by the lzss stream decoder modules
// ---------------------------------------------------------------------------
package lzsd_pkg;

	localparam int WINDOW_SIZE_DEF = 4096;
	localparam int MAX_MATCH_DEF   = 18;
	localparam int OFS_W           = 12;
	localparam int CNT_W           = 5;
	localparam int LEN_W           = 32;
	localparam int MIN_MATCH       = 3;
	localparam int FLAG_COUNT      = 8;

	// register index of output_length
	localparam logic REG_OUTPUT_LENGTH = 1'b0;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_done;
	} dec_item_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_LIT,
		KIND_COPY
	} kind_t;

	typedef struct packed {
		logic             restart;
		kind_t            kind;
		logic [7:0]       lit_byte;
		logic [OFS_W-1:0] src;
		logic [CNT_W-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic             busy;
		logic [LEN_W-1:0] produced;
	} eng_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_COPY
	} eng_state_t;

endpackage

// ===== hdl/lzss_stream_decoder_top.sv =====
// ---------------------------------------------------------------------------
// lzss_stream_decoder_top
// flag and literal bytes are parsed on acceptance; a flag or first match byte lets
// the next item in on the following cycle; a literal or match holds off the next
// item until its last byte is out, a match at one byte per cycle from the window
// read port unless the output stalls; reset clears control state at once; the window
// is not cleared, unwritten entries of this stream read as zero via the fill count
// ---------------------------------------------------------------------------
module lzss_stream_decoder_top #(
	parameter int WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF,
	parameter int MAX_MATCH   = lzsd_pkg::MAX_MATCH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  lzsd_pkg::byte_item_t byte_item,
	output logic                 dec_valid,
	input  logic                 dec_ready,
	output lzsd_pkg::dec_item_t  dec_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [lzsd_pkg::LEN_W-1:0] output_length_q;
	logic [7:0]                 flag_bits_q, flag_bits_d;
	logic [3:0]                 flags_left_q, flags_left_d;
	logic                       expect_second_q, expect_second_d;
	logic [7:0]                 first_byte_q, first_byte_d;

	logic                       accept;
	logic                       cfg_wr;
	lzsd_pkg::cmd_t             cmd;
	lzsd_pkg::eng_stat_t        stat;
	logic [lzsd_pkg::LEN_W-1:0] prod_eff;
	logic [lzsd_pkg::LEN_W-1:0] rem;
	logic [lzsd_pkg::CNT_W-1:0] cnt;
	logic [7:0]                 b;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && (paddr[2] == lzsd_pkg::REG_OUTPUT_LENGTH);
	assign prdata     = (paddr[2] == lzsd_pkg::REG_OUTPUT_LENGTH) ? output_length_q : '0;
	assign byte_ready = !stat.busy;
	assign accept     = byte_valid && byte_ready;
	assign b          = byte_item.in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_length_q <= '0;
		end else if (cfg_wr) begin
			output_length_q <= pwdata;
		end
	end

	always_comb begin
		if (byte_item.stream_start) begin
			flag_bits_d     = '0;
			flags_left_d    = '0;
			expect_second_d = 1'b0;
			prod_eff        = '0;
		end else begin
			flag_bits_d     = flag_bits_q;
			flags_left_d    = flags_left_q;
			expect_second_d = expect_second_q;
			prod_eff        = stat.produced;
		end
		first_byte_d = first_byte_q;
		rem          = output_length_q - prod_eff;
		cnt          = lzsd_pkg::CNT_W'(b[3:0]) + lzsd_pkg::CNT_W'(lzsd_pkg::MIN_MATCH);

		cmd.restart  = byte_item.stream_start;
		cmd.kind     = lzsd_pkg::KIND_NONE;
		cmd.lit_byte = b;
		cmd.src      = {b[7:4], first_byte_q};
		cmd.count    = (rem < lzsd_pkg::LEN_W'(cnt)) ? rem[lzsd_pkg::CNT_W-1:0] : cnt;

		if (prod_eff >= output_length_q) begin
			// stream complete: byte ignored
		end else if (expect_second_d) begin
			expect_second_d = 1'b0;
			cmd.kind        = lzsd_pkg::KIND_COPY;
		end else if (flags_left_d == '0) begin
			flag_bits_d  = b;
			flags_left_d = 4'(lzsd_pkg::FLAG_COUNT);
		end else begin
			if (flag_bits_d[0]) begin
				cmd.kind = lzsd_pkg::KIND_LIT;
			end else begin
				first_byte_d    = b;
				expect_second_d = 1'b1;
			end
			flag_bits_d  = flag_bits_d >> 1;
			flags_left_d = flags_left_d - 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_bits_q     <= '0;
			flags_left_q    <= '0;
			expect_second_q <= 1'b0;
		end else if (accept) begin
			flag_bits_q     <= flag_bits_d;
			flags_left_q    <= flags_left_d;
			expect_second_q <= expect_second_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_byte_q <= first_byte_d;
		end
	end

	lzsd_copy_engine #(
		.WINDOW_SIZE(WINDOW_SIZE),
		.MAX_MATCH  (MAX_MATCH)
	) u_copy_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (accept),
		.cmd           (cmd),
		.output_length (output_length_q),
		.stat          (stat),
		.out_valid     (dec_valid),
		.out_ready     (dec_ready),
		.out_item      (dec_item)
	);

endmodule

// ===== hdl/lzsd_win_ram.sv =====
// ---------------------------------------------------------------------------
// lzsd_win_ram
// history window: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module lzsd_win_ram #(
	parameter int DEPTH = lzsd_pkg::WINDOW_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/lzsd_copy_engine.sv =====
// ---------------------------------------------------------------------------
// lzsd_copy_engine
// window read / emit pipeline with forwarding, fill tracking and output register
// ---------------------------------------------------------------------------
module lzsd_copy_engine #(
	parameter int WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF,
	parameter int MAX_MATCH   = lzsd_pkg::MAX_MATCH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  lzsd_pkg::cmd_t                 cmd,
	input  logic [lzsd_pkg::LEN_W-1:0]     output_length,
	output lzsd_pkg::eng_stat_t            stat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output lzsd_pkg::dec_item_t            out_item
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int CW = $clog2(MAX_MATCH + 1);
	localparam logic [AW-1:0] WP_START = AW'(WINDOW_SIZE - MAX_MATCH);

	lzsd_pkg::eng_state_t state_q, state_d;

	logic [AW-1:0]              src_q;
	logic [CW-1:0]              remain_q;
	logic [AW-1:0]              wp_q;
	logic [lzsd_pkg::LEN_W-1:0] produced_q;
	logic                       vld_s1;
	logic                       lit_s1;
	logic [7:0]                 lit_byte_s1;
	logic                       fwd_s1;
	logic                       zero_s1;
	logic                       last_s1;
	logic [7:0]                 last_byte_q;
	logic                       out_valid_q;
	lzsd_pkg::dec_item_t        out_item_q;

	logic                       adv;
	logic                       emit;
	logic                       issue;
	logic [7:0]                 emit_byte;
	logic [7:0]                 rd_data;
	logic [lzsd_pkg::LEN_W-1:0] prod_next;
	logic [AW-1:0]              fill_ofs;
	logic                       written;
	logic                       fwd;
	logic                       done;

	assign adv       = !out_valid_q || out_ready;
	assign emit      = vld_s1 && adv;
	assign prod_next = produced_q + lzsd_pkg::LEN_W'(emit);
	assign done      = (prod_next == output_length);

	always_comb begin
		if (lit_s1) begin
			emit_byte = lit_byte_s1;
		end else if (fwd_s1) begin
			emit_byte = last_byte_q;
		end else if (zero_s1) begin
			emit_byte = 8'h00;
		end else begin
			emit_byte = rd_data;
		end
	end

	// entries are written in order from the start position, so the fill count says
	// which ones hold bytes of this stream
	assign fill_ofs = src_q - WP_START;
	assign written  = (prod_next[lzsd_pkg::LEN_W-1:AW] != '0) ||
	                  (fill_ofs < prod_next[AW-1:0]);
	assign fwd      = emit && (src_q == wp_q);

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		case (state_q)
			lzsd_pkg::ST_IDLE: begin
				if (cmd_valid && cmd.kind == lzsd_pkg::KIND_COPY) begin
					state_d = lzsd_pkg::ST_COPY;
				end
			end
			lzsd_pkg::ST_COPY: begin
				if (adv) begin
					issue = 1'b1;
					if (remain_q == CW'(1)) begin
						state_d = lzsd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = lzsd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzsd_pkg::ST_IDLE;
			remain_q    <= '0;
			wp_q        <= WP_START;
			produced_q  <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_valid) begin
				if (cmd.restart) begin
					wp_q       <= WP_START;
					produced_q <= '0;
				end
				if (cmd.kind == lzsd_pkg::KIND_COPY) begin
					remain_q <= CW'(cmd.count);
				end
				if (cmd.kind == lzsd_pkg::KIND_LIT) begin
					vld_s1 <= 1'b1;
				end
			end else begin
				if (emit) begin
					wp_q       <= wp_q + AW'(1);
					produced_q <= prod_next;
				end
				if (issue) begin
					vld_s1   <= 1'b1;
					remain_q <= remain_q - CW'(1);
				end else if (emit) begin
					vld_s1 <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid) begin
			src_q       <= AW'(cmd.src);
			lit_s1      <= (cmd.kind == lzsd_pkg::KIND_LIT);
			lit_byte_s1 <= cmd.lit_byte;
			last_s1     <= 1'b1;
		end else if (issue) begin
			src_q   <= src_q + AW'(1);
			lit_s1  <= 1'b0;
			fwd_s1  <= fwd;
			zero_s1 <= !written;
			last_s1 <= (remain_q == CW'(1));
		end
		if (emit) begin
			last_byte_q            <= emit_byte;
			out_item_q.out_byte    <= emit_byte;
			out_item_q.run_last    <= last_s1;
			out_item_q.stream_done <= done;
		end
	end

	lzsd_win_ram #(
		.DEPTH(WINDOW_SIZE)
	) u_win_ram (
		.clk   (clk),
		.we    (emit),
		.waddr (wp_q),
		.wdata (emit_byte),
		.re    (issue),
		.raddr (src_q),
		.rdata (rd_data)
	);

	assign stat.busy     = (state_q != lzsd_pkg::ST_IDLE) || vld_s1;
	assign stat.produced = produced_q;
	assign out_valid     = out_valid_q;
	assign out_item      = out_item_q;

endmodule

// ===== hdl/lzsd_checker.sv =====
// ---------------------------------------------------------------------------
// lzsd_checker
// port-level checks on the lzss stream decoder, bound to the top level
// ---------------------------------------------------------------------------
`include "lzss_stream_decoder_top_macros.svh"

module lzsd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_ready,
	input logic                 dec_valid,
	input logic                 dec_ready,
	input lzsd_pkg::dec_item_t  dec_item,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [2:0]           paddr,
	input logic [31:0]          pwdata,
	input logic [31:0]          prdata,
	input logic                 pready
);

	logic len_sel;
	logic len_wr;

	assign len_sel = (paddr[2] == lzsd_pkg::REG_OUTPUT_LENGTH);
	assign len_wr  = psel && penable && pwrite && pready && len_sel;

	// stalled result holds
	`LZSD_ASSERT_NEXT(a_out_hold, dec_valid && !dec_ready, dec_valid && $stable(dec_item), "result changed while stalled")

	// no new item while a match is still being expanded
	`LZSD_ASSERT_NOW(a_no_accept_mid_run, dec_valid && !dec_item.run_last, !byte_ready, "ready mid-run")

	// the clamp makes the completing byte the last of its run
	`LZSD_ASSERT_NOW(a_done_is_last, dec_valid && dec_item.stream_done, dec_item.run_last, "done without last")

	// length register reads back what was written
	`LZSD_ASSERT_NEXT(a_cfg_readback, len_wr, !len_sel || (prdata == $past(pwdata)), "length readback mismatch")

endmodule

bind lzss_stream_decoder_top lzsd_checker u_lzsd_checker (.*);

// ===== tb/lzsd_checker.sv =====
// ---------------------------------------------------------------------------
// tb_checker
// watches the byte, decoded and register channels of the lzss stream decoder,
// keeps its own copy of the history window and parser state, predicts the
// decoded items of every accepted byte and compares them in order
// ---------------------------------------------------------------------------
module tb_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic                 byte_ready,
	input  lzsd_pkg::byte_item_t byte_item,
	input  logic                 dec_valid,
	input  logic                 dec_ready,
	input  lzsd_pkg::dec_item_t  dec_item,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	input  logic                 pready,
	output int                   fail_count,
	output int                   pending
);

	localparam int          WIN_DEPTH = 4096;
	localparam logic [11:0] WIN_START = 12'd4078;
	localparam int          SHOW_MAX  = 10;

	logic [7:0]          hist [WIN_DEPTH];
	logic [11:0]         wr_pos;
	logic [7:0]          flag_reg;
	logic [3:0]          flags_left;
	logic                second_due;
	logic [7:0]          ofs_low;
	logic [31:0]         out_count;
	logic [31:0]         out_len;
	lzsd_pkg::dec_item_t decoded_q[$];

	task automatic clear_stream();
		foreach (hist[i]) hist[i] = 8'h00;
		wr_pos     = WIN_START;
		flag_reg   = 8'h00;
		flags_left = 4'd0;
		second_due = 1'b0;
		ofs_low    = 8'h00;
		out_count  = 32'd0;
	endtask

	// one decoded byte goes into the window and out as an item
	function automatic lzsd_pkg::dec_item_t record_byte(input logic [7:0] b);
		lzsd_pkg::dec_item_t d;
		hist[wr_pos] = b;
		wr_pos       = wr_pos + 12'd1;
		out_count    = out_count + 32'd1;
		d.out_byte    = b;
		d.run_last    = 1'b0;
		d.stream_done = (out_count == out_len);
		return d;
	endfunction

	task automatic decode_byte(input lzsd_pkg::byte_item_t it);
		lzsd_pkg::dec_item_t run[$];
		lzsd_pkg::dec_item_t tail;
		logic [11:0]         src;
		int unsigned         span;
		int unsigned         i;
		logic                lit;
		if (it.stream_start) clear_stream();
		if (out_count >= out_len) return;
		if (second_due) begin
			second_due = 1'b0;
			src  = {it.in_byte[7:4], ofs_low};
			span = int'(it.in_byte[3:0]) + lzsd_pkg::MIN_MATCH;
			for (i = 0; i < span && out_count < out_len; i++)
				run.push_back(record_byte(hist[src + 12'(i)]));
		end else if (flags_left == 4'd0) begin
			flag_reg   = it.in_byte;
			flags_left = 4'(lzsd_pkg::FLAG_COUNT);
		end else begin
			lit        = flag_reg[0];
			flag_reg   = flag_reg >> 1;
			flags_left = flags_left - 4'd1;
			if (lit) begin
				run.push_back(record_byte(it.in_byte));
			end else begin
				ofs_low    = it.in_byte;
				second_due = 1'b1;
			end
		end
		if (run.size() > 0) begin
			tail = run.pop_back();
			tail.run_last = 1'b1;
			run.push_back(tail);
			foreach (run[k]) decoded_q.push_back(run[k]);
		end
	endtask

	task automatic check_out(input lzsd_pkg::dec_item_t got);
		lzsd_pkg::dec_item_t want;
		if (decoded_q.size() == 0) begin
			fail_count++;
			if (fail_count <= SHOW_MAX)
				$display("unexpected decoded item: byte %h last %b done %b",
					got.out_byte, got.run_last, got.stream_done);
			return;
		end
		want = decoded_q.pop_front();
		if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
				got.stream_done !== want.stream_done) begin
			fail_count++;
			if (fail_count <= SHOW_MAX)
				$display("decoded item mismatch: expected byte %h last %b done %b, %s %h %s %b %s %b",
					want.out_byte, want.run_last, want.stream_done,
					"got byte", got.out_byte, "last", got.run_last, "done", got.stream_done);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stream();
			out_len = 32'd0;
			decoded_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (byte_valid && byte_ready) decode_byte(byte_item);
			if (psel && penable && pwrite && pready &&
					paddr[2] == lzsd_pkg::REG_OUTPUT_LENGTH)
				out_len = pwdata;
			if (dec_valid && dec_ready) check_out(dec_item);
			pending = decoded_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// drives compressed byte streams into the lzss stream decoder: a directed set
// covering literals, shortest and longest matches, window wrap, clamping at
// the decoded length and length changes, then random well-formed streams with
// some noise, under bursty input, a patterned output stall and one long hold
// ---------------------------------------------------------------------------
module tb_top;

	localparam logic [2:0]  LEN_ADDR      = {lzsd_pkg::REG_OUTPUT_LENGTH, 2'b00};
	localparam int          SETTLE_CYCLES = 40;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          RANDOM_TARGET = 88;
	localparam logic [11:0] WIN_START     = 12'd4078;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_SPARSE
	} rx_mode_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_ready;
	lzsd_pkg::byte_item_t byte_item  = '0;
	logic                 dec_valid;
	logic                 dec_ready  = 1'b0;
	lzsd_pkg::dec_item_t  dec_item;
	logic                 psel       = 1'b0;
	logic                 penable    = 1'b0;
	logic                 pwrite     = 1'b0;
	logic [2:0]           paddr      = '0;
	logic [31:0]          pwdata     = '0;
	logic [31:0]          prdata;
	logic                 pready;
	int                   fail_count;
	int                   pending;

	int          burst_left = 0;
	int          fed_items  = 0;
	logic [11:0] gen_wp     = WIN_START;
	logic        stall_req  = 1'b0;
	logic        hold_done  = 1'b0;

	always #2 clk = ~clk;

	lzss_stream_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_item  (dec_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	tb_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_item  (dec_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.fail_count(fail_count),
		.pending   (pending)
	);

	task automatic send_byte(input logic [7:0] b, input logic s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		fed_items++;
		byte_valid <= 1'b1;
		byte_item  <= '{in_byte: b, stream_start: s};
		do @(posedge clk); while (!byte_ready);
	endtask

	task automatic settle();
		byte_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LEN_ADDR;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly matches near the write position so copies hit written history
	task automatic send_stream(input int groups);
		logic [7:0]  flags;
		logic [11:0] ofs;
		logic [3:0]  len4;
		int          stop_at;
		int          g;
		int          f;
		gen_wp = WIN_START;
		for (g = 0; g < groups; g++) begin
			if (fed_items >= RANDOM_TARGET) break;
			flags   = 8'($urandom);
			stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) :
			          lzsd_pkg::FLAG_COUNT;
			send_byte(flags, g == 0);
			for (f = 0; f < stop_at; f++) begin
				if ($urandom_range(0, 19) == 0)
					send_byte(8'($urandom), $urandom_range(0, 3) == 0);
				if (flags[f]) begin
					send_byte(8'($urandom), 1'b0);
					gen_wp = gen_wp + 12'd1;
				end else begin
					len4 = 4'($urandom);
					if ($urandom_range(0, 9) < 7)
						ofs = gen_wp - 12'($urandom_range(1, 20));
					else
						ofs = 12'($urandom);
					send_byte(ofs[7:0], 1'b0);
					send_byte({ofs[11:8], len4}, 1'b0);
					gen_wp = gen_wp + 12'(len4) + 12'(lzsd_pkg::MIN_MATCH);
				end
			end
		end
	endtask

	initial begin
		rx_mode_t mode;
		int       left;
		int       i;
		mode = RX_OPEN;
		left = 0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				dec_ready <= 1'b0;
				for (i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(8, 64);
				end
				left--;
				case (mode)
					RX_OPEN:   dec_ready <= 1'b1;
					RX_COIN:   dec_ready <= 1'($urandom);
					RX_MOSTLY: dec_ready <= ($urandom_range(0, 4) != 0);
					default:   dec_ready <= (left[1:0] == 2'b00);
				endcase
			end
		end
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int          pick;
		logic [31:0] new_len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// literals at both extremes, shortest and longest match, overlap and wrap
		set_length('1);
		send_byte(8'h55, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hEE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h3A, 1'b0);
		settle();

		// longest match clamped at the decoded length, then ignored bytes
		set_length(32'd5);
		send_byte(8'h00, 1'b1);
		send_byte(8'h34, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hA5, 1'b0);
		settle();

		// zero length
		set_length(32'd0);
		send_byte(8'hC3, 1'b1);
		settle();

		// length raised, reached, then lowered below the count mid-stream
		set_length(32'd4);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		settle();
		set_length(32'd3);
		send_byte(8'h33, 1'b0);
		settle();
		set_length(32'd1);
		send_byte(8'h44, 1'b0);
		settle();

		fed_items = 0;
		while (fed_items < RANDOM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (!hold_done && fed_items >= RANDOM_TARGET / 3) begin
				set_length('1);
				stall_req = 1'b1;
				hold_done = 1'b1;
				send_stream(3);
			end else begin
				if (pick < 6)
					new_len = 32'($urandom_range(1, 48));
				else if (pick < 8)
					new_len = '1;
				else
					new_len = {1'b1, 31'($urandom)};
				set_length(new_len);
				repeat ($urandom_range(1, 2)) send_stream($urandom_range(1, 3));
			end
			settle();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
